### rtl/go_to_goal_grid_controller_unit_assert.svh
// Assertion macros for the checker file.
`ifndef GO_TO_GOAL_GRID_CONTROLLER_UNIT_ASSERT_SVH
`define GO_TO_GOAL_GRID_CONTROLLER_UNIT_ASSERT_SVH
// Clocked check, held off while reset is low.
`define GTG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gtg assertion failed");
// Clocked check that also runs during reset.
`define GTG_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("gtg assertion failed");
`endif

### rtl/gtg_pkg.sv
`timescale 1ns / 1ps
package gtg_pkg;
  localparam int POSITION_BITS = 24;
  localparam int CORDIC_STAGES = 16;
  localparam int DW = (POSITION_BITS > 20 ? POSITION_BITS : 20) + 4;
  localparam int AW = DW - 1;
  localparam int SHW = 5;
  localparam logic [17:0] PI_Q16 = 18'd205887;

  typedef enum logic [2:0] {
    CFG_GRID_SIZE = 3'd0,
    CFG_SPACING   = 3'd1,
    CFG_DIST_TOL  = 3'd2,
    CFG_HEAD_TOL  = 3'd3,
    CFG_FWD_SPEED = 3'd4,
    CFG_TURN_GAIN = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                 valid;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic [15:0]          z;
  } cord_t;

  function automatic logic [15:0] atan_unit(input int idx);
    logic [15:0] a;
    case (idx)
      0:  a = 16'd8192;
      1:  a = 16'd4836;
      2:  a = 16'd2555;
      3:  a = 16'd1297;
      4:  a = 16'd651;
      5:  a = 16'd326;
      6:  a = 16'd163;
      7:  a = 16'd81;
      8:  a = 16'd41;
      9:  a = 16'd20;
      10: a = 16'd10;
      11: a = 16'd5;
      12: a = 16'd3;
      13: a = 16'd1;
      14: a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction
endpackage

### rtl/gtg_cordic_cell.sv
`timescale 1ns / 1ps
module gtg_cordic_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [gtg_pkg::SHW-1:0] shift_i,
  input  logic [15:0]           angle_i,
  input  gtg_pkg::cord_t        cell_i,
  output gtg_pkg::cord_t        cell_o
);
  logic signed [gtg_pkg::DW-1:0] xs, ys, x_d, y_d;
  logic [15:0] z_d;
  logic valid_q;
  logic signed [gtg_pkg::DW-1:0] x_q, y_q;
  logic [15:0] z_q;

  always_comb begin
    xs = cell_i.x >>> shift_i;
    ys = cell_i.y >>> shift_i;
    if (!cell_i.y[gtg_pkg::DW-1]) begin
      x_d = cell_i.x + ys;
      y_d = cell_i.y - xs;
      z_d = cell_i.z + angle_i;
    end else begin
      x_d = cell_i.x - ys;
      y_d = cell_i.y + xs;
      z_d = cell_i.z - angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign cell_o = '{valid: valid_q, x: x_q, y: y_q, z: z_q};
endmodule

### rtl/go_to_goal_grid_controller_unit.sv
`timescale 1ns / 1ps
// Each pose sample is captured, its goal offset registered and its vector walked
// through the row of CORDIC cells; the MUL1 and MUL2 states form the turn command.
// One sample is in flight at a time: a new one is taken only once the last one's
// command is registered. Reset: asynchronous, active low; the state, output valid
// and config registers return to defaults and the waypoint to column 0, row 0.
module go_to_goal_grid_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x, pos_y, heading
  input  logic [2*gtg_pkg::POSITION_BITS+15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // linear_speed, angular_speed, goal_reached, heading_error, goal_column,
  // goal_row, zero fill
  output logic [55:0] m_axis_tdata
);
  localparam int PB = gtg_pkg::POSITION_BITS;
  localparam int DW = gtg_pkg::DW;
  localparam int AW = gtg_pkg::AW;
  localparam int NS = gtg_pkg::CORDIC_STAGES;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIFF = 7'b0000010,
    S_FEED = 7'b0000100,
    S_WAIT = 7'b0001000,
    S_MUL1 = 7'b0010000,
    S_MUL2 = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]  grid_q;
  logic [15:0] spacing_q, dtol_q, gain_q;
  logic [14:0] htol_q;
  logic [11:0] fwd_q;
  logic [3:0]  col_q, row_q;

  logic signed [PB-1:0] px_q, py_q;
  logic [15:0] yaw_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [2*AW-1:0] sqx_q, sqy_q;
  logic [31:0] t2_q;
  logic zero_q, near_q, turn_q, neg_q;
  logic [15:0] eu_q, aerr_q;
  logic [31:0] p1_q;
  logic [49:0] p2_q;

  logic out_valid_q;
  logic [55:0] out_data_q;

  gtg_pkg::cord_t chain [NS+1];

  // Column and row goal offsets are unsigned, at most 20 bits.
  logic [19:0] gx, gy;
  logic signed [DW-1:0] dx_d, dy_d;
  logic [AW-1:0] adx, ady;
  logic [15:0] bearing, eu_d, aerr_d;
  logic [16:0] mag;
  logic [15:0] ang;
  logic [11:0] lin;
  logic [4:0] row_inc, col_inc;
  logic out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    gx   = col_q * spacing_q;
    gy   = row_q * spacing_q;
    dx_d = $signed({{(DW-20){1'b0}}, gx}) - DW'(px_q);
    dy_d = $signed({{(DW-20){1'b0}}, gy}) - DW'(py_q);
    adx  = dx_q[DW-1] ? AW'(-dx_q) : AW'(dx_q);
    ady  = dy_q[DW-1] ? AW'(-dy_q) : AW'(dy_q);
  end

  // Pre-rotation by half a turn puts the vector in the right half plane.
  always_comb begin
    chain[0].valid = state_q == S_FEED;
    chain[0].x     = dx_q[DW-1] ? -dx_q : dx_q;
    chain[0].y     = dx_q[DW-1] ? -dy_q : dy_q;
    chain[0].z     = dx_q[DW-1] ? 16'h8000 : 16'h0000;
  end

  for (genvar g = 0; g < NS; g++) begin : g_cell
    gtg_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(gtg_pkg::SHW'(g)),
      .angle_i(gtg_pkg::atan_unit(g)),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  always_comb begin
    bearing = zero_q ? 16'h0000 : chain[NS].z;
    eu_d    = bearing - yaw_q;
    aerr_d  = eu_d[15] ? 16'(-eu_d) : eu_d;
    mag     = 17'((p2_q + 50'h1_0000_0000) >> 33);
    if (neg_q) begin
      ang = (mag > 17'd32768) ? 16'h8000 : 16'(-mag);
    end else begin
      ang = (mag > 17'd32767) ? 16'h7fff : mag[15:0];
    end
    lin = 12'd0;
    if (near_q) begin
      ang = 16'd0;
    end else if (!turn_q) begin
      ang = 16'd0;
      lin = fwd_q;
    end
    row_inc = {1'b0, row_q} + 5'd1;
    col_inc = {1'b0, col_q} + 5'd1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_DIFF;
      S_DIFF: state_d = S_FEED;
      S_FEED: state_d = S_WAIT;
      S_WAIT: if (chain[NS].valid) state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      grid_q      <= 4'd3;
      spacing_q   <= 16'd1024;
      dtol_q      <= 16'd102;
      htol_q      <= 15'd1043;
      fwd_q       <= 12'd307;
      gain_q      <= 16'd2048;
      col_q       <= 4'd0;
      row_q       <= 4'd0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (gtg_pkg::cfg_idx_e'(cfg_addr_i))
          gtg_pkg::CFG_GRID_SIZE: grid_q    <= cfg_data_i[3:0];
          gtg_pkg::CFG_SPACING:   spacing_q <= cfg_data_i;
          gtg_pkg::CFG_DIST_TOL:  dtol_q    <= cfg_data_i;
          gtg_pkg::CFG_HEAD_TOL:  htol_q    <= cfg_data_i[14:0];
          gtg_pkg::CFG_FWD_SPEED: fwd_q     <= cfg_data_i[11:0];
          gtg_pkg::CFG_TURN_GAIN: gain_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tready && !(state_q == S_DONE && out_free)) out_valid_q <= 1'b0;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        if (near_q) begin
          if (row_inc > {1'b0, grid_q}) begin
            row_q <= 4'd0;
            col_q <= (col_inc > {1'b0, grid_q}) ? 4'd0 : col_inc[3:0];
          end else begin
            row_q <= row_inc[3:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      px_q  <= s_axis_tdata[PB-1:0];
      py_q  <= s_axis_tdata[2*PB-1:PB];
      yaw_q <= s_axis_tdata[2*PB+15:2*PB];
    end
    if (state_q == S_DIFF) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (state_q == S_FEED) begin
      sqx_q  <= adx * adx;
      sqy_q  <= ady * ady;
      t2_q   <= dtol_q * dtol_q;
      zero_q <= dx_q == '0 && dy_q == '0;
    end
    if (state_q == S_WAIT) begin
      near_q <= ({1'b0, sqx_q} + {1'b0, sqy_q}) <= (2*AW+1)'(t2_q);
      eu_q   <= eu_d;
      aerr_q <= aerr_d;
      neg_q  <= eu_d[15];
      turn_q <= aerr_d > {1'b0, htol_q};
    end
    if (state_q == S_MUL1) p1_q <= gain_q * aerr_q;
    if (state_q == S_MUL2) p2_q <= p1_q * gtg_pkg::PI_Q16;
    if (state_q == S_DONE && out_free) begin
      out_data_q <= {3'b000, row_q, col_q, eu_q, near_q, ang, lin};
    end
  end
endmodule

### rtl/gtg_checker.sv
`timescale 1ns / 1ps
`include "go_to_goal_grid_controller_unit_assert.svh"
module gtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  `GTG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `GTG_ASSERT(a_reached_stops, m_axis_tvalid && m_axis_tdata[28] |-> m_axis_tdata[27:0] == 28'd0)
  `GTG_ASSERT(a_drive_no_turn, m_axis_tvalid && m_axis_tdata[11:0] != 12'd0 |-> m_axis_tdata[27:12] == 16'd0)
  `GTG_ASSERT(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
endmodule

bind go_to_goal_grid_controller_unit gtg_checker u_gtg_checker (.*);

### tb/tb_go_to_goal_grid_controller_unit.sv
`timescale 1ns / 1ps
module tb_go_to_goal_grid_controller_unit;
  import gtg_pkg::*;

  localparam int PB = POSITION_BITS;

  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] err;
    logic        reached;
    logic [15:0] ang;
    logic [11:0] lin;
  } cmd_t;

  class heading_scoreboard;
    logic [3:0]  grid_size;
    logic [15:0] spacing;
    logic [15:0] dist_tol;
    logic [14:0] head_tol;
    logic [11:0] fwd_speed;
    logic [15:0] turn_gain;
    logic [3:0]  wp_col;
    logic [3:0]  wp_row;
    cmd_t        pending[$];
    int          errors;

    function new();
      grid_size = 4'd3;
      spacing   = 16'd1024;
      dist_tol  = 16'd102;
      head_tol  = 15'd1043;
      fwd_speed = 12'd307;
      turn_gain = 16'd2048;
      wp_col    = '0;
      wp_row    = '0;
      errors    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_GRID_SIZE: grid_size = val[3:0];
        CFG_SPACING:   spacing   = val;
        CFG_DIST_TOL:  dist_tol  = val;
        CFG_HEAD_TOL:  head_tol  = val[14:0];
        CFG_FWD_SPEED: fwd_speed = val[11:0];
        CFG_TURN_GAIN: turn_gain = val;
        default: ;
      endcase
    endfunction

    // Floor shift, as an arithmetic shift of a two's complement value.
    function longint asr(longint v, int s);
      return v >>> s;
    endfunction

    function logic [15:0] bearing(longint dx, longint dy);
      longint x, y, xs, ys;
      logic [15:0] z;
      logic [15:0] a;
      int i;
      x = dx;
      y = dy;
      z = 16'd0;
      if (dx == 0 && dy == 0) return 16'd0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 16'h8000;
      end
      for (i = 0; i < CORDIC_STAGES; i++) begin
        xs = asr(x, i);
        ys = asr(y, i);
        case (i)
          0: a = 16'd8192; 1: a = 16'd4836; 2: a = 16'd2555; 3: a = 16'd1297;
          4: a = 16'd651; 5: a = 16'd326; 6: a = 16'd163; 7: a = 16'd81;
          8: a = 16'd41; 9: a = 16'd20; 10: a = 16'd10; 11: a = 16'd5;
          12: a = 16'd3; 13: a = 16'd1; 14: a = 16'd1;
          default: a = 16'd0;
        endcase
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + a;
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - a;
        end
      end
      return z;
    endfunction

    function void note_pose(logic signed [PB-1:0] px, logic signed [PB-1:0] py,
                            logic [15:0] yaw);
      longint dx, dy, d2, t2, aerr, mag;
      longint unsigned prod;
      logic [15:0] eu;
      logic [4:0] r, c;
      cmd_t o;
      dx = longint'(wp_col) * longint'(spacing) - longint'(px);
      dy = longint'(wp_row) * longint'(spacing) - longint'(py);
      d2 = dx * dx + dy * dy;
      t2 = longint'(dist_tol) * longint'(dist_tol);
      eu = bearing(dx, dy) - yaw;
      aerr = eu[15] ? 65536 - longint'(eu) : longint'(eu);
      o = '0;
      o.err = eu;
      o.col = wp_col;
      o.row = wp_row;
      if (d2 > t2) begin
        if (aerr > longint'(head_tol)) begin
          prod = longint'(turn_gain) * aerr * 205887;
          mag = (prod + (64'd1 << 32)) >> 33;
          if (eu[15]) o.ang = (mag > 32768) ? 16'h8000 : 16'(-mag);
          else o.ang = (mag > 32767) ? 16'h7fff : 16'(mag);
        end else begin
          o.lin = fwd_speed;
        end
      end else begin
        o.reached = 1'b1;
      end
      pending.push_back(o);
      if (o.reached) begin
        r = wp_row + 5'd1;
        if (r > grid_size) begin
          c = wp_col + 5'd1;
          r = 5'd0;
          if (c > grid_size) c = 5'd0;
          wp_col = c[3:0];
        end
        wp_row = r[3:0];
      end
    endfunction

    function void check_cmd(cmd_t got);
      cmd_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected command %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.lin !== e.lin)
        $display("%0t: linear_speed exp %0d got %0d", $realtime, e.lin, got.lin);
      if (got.ang !== e.ang)
        $display("%0t: angular_speed exp %0d got %0d", $realtime,
                 $signed(e.ang), $signed(got.ang));
      if (got.reached !== e.reached)
        $display("%0t: goal_reached exp %0d got %0d", $realtime, e.reached, got.reached);
      if (got.err !== e.err)
        $display("%0t: heading_error exp %0d got %0d", $realtime,
                 $signed(e.err), $signed(got.err));
      if (got.col !== e.col)
        $display("%0t: goal_column exp %0d got %0d", $realtime, e.col, got.col);
      if (got.row !== e.row)
        $display("%0t: goal_row exp %0d got %0d", $realtime, e.row, got.row);
      if (got !== e) errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [2*PB+15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  heading_scoreboard sb;
  bit stall_enable = 1'b1;

  go_to_goal_grid_controller_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pose(logic [PB-1:0] px, logic [PB-1:0] py, logic [15:0] yaw,
                           bit idle);
    int g;
    if (idle) begin
      g = gap_len();
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {yaw, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pose(px, py, yaw);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (CORDIC_STAGES + 20) @(posedge clk_i);
  endtask

  // Pose near the current waypoint, so goals can be met and the grid walk advances.
  task automatic near_pose(bit idle);
    longint gx, gy, ox, oy;
    gx = longint'(sb.wp_col) * sb.spacing;
    gy = longint'(sb.wp_row) * sb.spacing;
    ox = $signed($urandom_range(0, 2 * sb.dist_tol + 8)) - sb.dist_tol - 4;
    oy = $signed($urandom_range(0, 2 * sb.dist_tol + 8)) - sb.dist_tol - 4;
    send_pose(PB'(gx + ox), PB'(gy + oy), 16'($urandom), idle);
  endtask

  task automatic random_phase(int n);
    int i, k;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 4) near_pose(1);
      else if (k < 7)
        send_pose(PB'($signed($urandom_range(0, 40000)) - 20000),
                  PB'($signed($urandom_range(0, 40000)) - 20000), 16'($urandom), 1);
      else send_pose(PB'($urandom), PB'($urandom), 16'($urandom), 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_cmd(cmd_t'(m_axis_tdata[52:0]));
  end

  always @(posedge clk_i) begin
    if (!stall_enable) m_axis_tready <= 1'b1;
    else if ($urandom_range(0, 9) < 7) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 20) == 0);
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int p;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero vector, field extremes, turn saturation, both wrap edges.
    send_pose('0, '0, 16'h0000, 0);
    send_pose('0, '0, 16'h8000, 0);
    send_pose({1'b0, {(PB-1){1'b1}}}, {1'b0, {(PB-1){1'b1}}}, 16'h7fff, 0);
    send_pose({1'b1, {(PB-1){1'b0}}}, {1'b1, {(PB-1){1'b0}}}, 16'h8000, 0);
    send_pose({1'b1, {(PB-1){1'b0}}}, 24'd0, 16'h0000, 0);
    send_pose(24'd5000, 24'd0, 16'h0000, 0);
    send_pose(24'd5000, 24'd10, 16'h4000, 0);
    send_pose(-24'sd3000, 24'd2, 16'hc000, 0);
    send_pose('1, '1, 16'hffff, 0);
    drain();
    write_reg(CFG_TURN_GAIN, 16'hffff);
    write_reg(CFG_HEAD_TOL, 16'd0);
    write_reg(CFG_GRID_SIZE, 16'd0);
    drain();
    send_pose(-24'sd3000, 24'd1, 16'h0000, 0);
    send_pose(-24'sd3000, -24'sd1, 16'h0000, 0);
    send_pose(24'd3000, 24'd0, 16'h8000, 0);
    send_pose(24'd0, 24'd0, 16'h1234, 0);
    send_pose(24'd0, 24'd0, 16'h1234, 0);
    drain();
    write_reg(CFG_SPACING, 16'hffff);
    write_reg(CFG_DIST_TOL, 16'hffff);
    write_reg(CFG_FWD_SPEED, 16'hfff);
    write_reg(CFG_GRID_SIZE, 16'd15);
    drain();
    for (p = 0; p < 6; p++) near_pose(0);
    drain();

    for (p = 0; p < 9; p++) begin
      stall_enable = (p != 3);
      case (p)
        0: begin
          write_reg(CFG_SPACING, 16'd1024); write_reg(CFG_DIST_TOL, 16'd102);
          write_reg(CFG_GRID_SIZE, 16'd3);
        end
        1: begin
          write_reg(CFG_HEAD_TOL, 16'h7fff); write_reg(CFG_FWD_SPEED, 16'd0);
        end
        2: begin
          write_reg(CFG_HEAD_TOL, 16'($urandom)); write_reg(CFG_TURN_GAIN, 16'($urandom));
          write_reg(CFG_FWD_SPEED, 16'($urandom));
        end
        3: begin
          write_reg(CFG_DIST_TOL, 16'd0); write_reg(CFG_SPACING, 16'd1);
        end
        4: begin
          write_reg(CFG_SPACING, 16'hffff); write_reg(CFG_DIST_TOL, 16'd2000);
          write_reg(CFG_GRID_SIZE, 16'd15);
        end
        5: write_reg(CFG_GRID_SIZE, 16'd1);
        default: begin
          write_reg(CFG_GRID_SIZE, 16'($urandom));
          write_reg(CFG_SPACING, 16'($urandom_range(1, 65535)));
          write_reg(CFG_DIST_TOL, 16'($urandom_range(0, 3000)));
          write_reg(CFG_HEAD_TOL, 16'($urandom_range(0, 4000)));
          write_reg(CFG_TURN_GAIN, 16'($urandom));
        end
      endcase
      random_phase(150);
      drain();
    end

    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
